/* hw/rtl/integer_to_ascii_formatter_unit_defines.svh */
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define IFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define IFA_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IFA_ASSERT(label, prop, msg)
`define IFA_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* hw/rtl/ifa_pkg.sv */
`default_nettype none

package ifa_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // request kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_DEC  = 2'd2;
    localparam logic [1:0] KIND_HEX  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

    // classification handed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic       neg;
        logic       is_nl;
    } ifa_ctl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DEC_BASE)
        begin
            return CH_ZERO + d_ext;
        end
        return CH_A + d_ext - CHAR_W'(DEC_BASE);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ifa_channels.sv */
`default_nettype none

interface ifa_req_if
    import ifa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface ifa_char_if
    import ifa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ifa_queue.sv */
`default_nettype none

// two-slot queue, head always in slot 0
module ifa_queue #(
    parameter int WIDTH = 36
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] slot0_reg, slot0_next;
    logic [WIDTH-1:0] slot1_reg, slot1_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (count_reg == '0 || (pop && count_reg == CNT_W'(1)))
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/ifa_front.sv */
`default_nettype none

// Classifies requests: masks the number, takes the decimal magnitude,
// flags a newline that needs a CR in front.
module ifa_front
    import ifa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    ifa_req_if.sink               req,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output ifa_ctl_t              q_ctl,
    output logic [VALUE_BITS-1:0] q_mag
);

    localparam int EXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    logic [EXT_W-1:0]      val_ext;
    logic [VALUE_BITS-1:0] val;
    logic                  neg;

    assign val_ext = EXT_W'(req.value);
    assign val     = val_ext[VALUE_BITS-1:0];
    assign neg     = (req.req_type == KIND_DEC) && val[VALUE_BITS-1];

    assign q_valid     = req.valid;
    assign req.ready   = q_ready;
    assign q_mag       = neg ? (VALUE_BITS'(0) - val) : val;
    assign q_ctl.kind  = req.req_type;
    assign q_ctl.neg   = neg;
    assign q_ctl.is_nl = (req.req_type == KIND_TEXT) && (req.value[CHAR_W-1:0] == CH_LF);

endmodule

`default_nettype wire

/* hw/rtl/ifa_back.sv */
`default_nettype none
`include "integer_to_ascii_formatter_unit_defines.svh"

// Converts one queued request into characters. Decimal goes through a
// shift-add-3 BCD converter, one bit per cycle; hex loads nibbles directly.
module ifa_back
    import ifa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire ifa_ctl_t              q_ctl,
    input  wire logic [VALUE_BITS-1:0] q_mag,
    ifa_char_if.source                 chars
);

    localparam int DEC_DIGITS = (VALUE_BITS * 3 + 9) / 10;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int IDX_W      = $clog2(DEC_DIGITS);
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BC_W       = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHAR  = 3'd1;
    localparam logic [2:0] ST_CONV  = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic                  sign_pending_reg, sign_pending_next;
    logic                  cr_pending_reg, cr_pending_next;
    logic [CNT_W-1:0]      digit_count_reg, digit_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic [DIGIT_W-1:0]    digit_store [DEC_DIGITS];
    logic [DIGIT_W-1:0]    store_next [DEC_DIGITS];

    logic [DIGIT_W-1:0]        adj [DEC_DIGITS];
    logic [DIGIT_W-1:0]        dabble [DEC_DIGITS];
    logic [DIGIT_W-1:0]        hex_nib [DEC_DIGITS];
    logic [HEX_DIGITS*4-1:0]   mag_pad;
    logic [CNT_W-1:0]          top_count;
    logic                      out_load;
    logic                      emit;
    logic                      emit_last;
    logic [CHAR_W-1:0]         emit_char;

    assign out_load        = !out_valid_reg || chars.ready;
    assign q_ready         = (state_reg == ST_IDLE);
    assign chars.valid     = out_valid_reg;
    assign chars.out_char  = out_char_reg;
    assign chars.last_char = out_last_reg;

    // add-3 correction then one-bit left shift through all digits
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            adj[i] = (digit_store[i] >= 4'd5) ? digit_store[i] + 4'd3 : digit_store[i];
        end
        dabble[0] = {adj[0][DIGIT_W-2:0], mag_reg[VALUE_BITS-1]};
        for (int i = 1; i < DEC_DIGITS; i++)
        begin
            dabble[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
        end
    end

    assign mag_pad = (HEX_DIGITS * 4)'(q_mag);

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            hex_nib[i] = '0;
        end
        for (int i = 0; i < HEX_DIGITS; i++)
        begin
            hex_nib[i] = mag_pad[4*i +: 4];
        end
    end

    // position of the top nonzero digit, at least one digit
    always_comb
    begin
        top_count = CNT_W'(1);
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (digit_store[i] != '0)
            begin
                top_count = CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        sign_pending_next = sign_pending_reg;
        cr_pending_next   = cr_pending_reg;
        digit_count_next  = digit_count_reg;
        bit_cnt_next      = bit_cnt_reg;
        mag_next          = mag_reg;
        idx_next          = idx_reg;
        store_next        = digit_store;
        emit              = 1'b0;
        emit_last         = 1'b0;
        emit_char         = CH_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    mag_next        = q_mag;
                    cr_pending_next = q_ctl.is_nl;
                    case (q_ctl.kind)
                        KIND_TEXT, KIND_RAW:
                        begin
                            state_next = ST_CHAR;
                        end
                        KIND_DEC:
                        begin
                            sign_pending_next = q_ctl.neg;
                            for (int i = 0; i < DEC_DIGITS; i++)
                            begin
                                store_next[i] = '0;
                            end
                            bit_cnt_next = BC_W'(VALUE_BITS);
                            state_next   = ST_CONV;
                        end
                        KIND_HEX:
                        begin
                            sign_pending_next = 1'b0;
                            store_next        = hex_nib;
                            state_next        = ST_COUNT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHAR:
            begin
                if (out_load)
                begin
                    emit = 1'b1;
                    if (cr_pending_reg)
                    begin
                        emit_char       = CH_CR;
                        cr_pending_next = 1'b0;
                    end
                    else
                    begin
                        emit_char  = mag_reg[CHAR_W-1:0];
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CONV:
            begin
                store_next   = dabble;
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - BC_W'(1);
                if (bit_cnt_reg == BC_W'(1))
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                digit_count_next = top_count;
                idx_next         = IDX_W'(top_count - CNT_W'(1));
                state_next       = sign_pending_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (out_load)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_load)
                begin
                    emit      = 1'b1;
                    emit_char = digit_char(digit_store[idx_reg]);
                    emit_last = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sign_pending_reg <= 1'b0;
            cr_pending_reg   <= 1'b0;
            digit_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
            bit_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            sign_pending_reg <= sign_pending_next;
            cr_pending_reg   <= cr_pending_next;
            digit_count_reg  <= digit_count_next;
            out_valid_reg    <= out_valid_next;
            bit_cnt_reg      <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        digit_store  <= store_next;
    end

    `IFA_ASSERT(a_idx_in_range, (state_reg == ST_DIGIT) |-> (CNT_W'(idx_reg) < digit_count_reg), "digit index beyond digit count")
    `IFA_ASSERT(a_last_ends_run, (emit && emit_last) |=> (state_reg == ST_IDLE), "last character did not end the run")
    `IFA_ASSERT(a_count_nonzero, (state_reg == ST_COUNT) |=> (digit_count_reg != '0), "empty digit run")
    `IFA_ASSERT_NEVER(a_no_overwrite, out_valid_reg && !chars.ready && emit, "output register overwritten while stalled")

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter_unit.sv */
// Integer to ASCII formatter, at most one character per cycle out, and only while chars.ready is high.
// A text or raw request passes the queue, the back end's state register and the output register
// before its first character shows; a decimal request also goes through the bit-serial BCD
// conversion and the digit-count state, hex through the digit-count state. The back end takes
// a new request only when idle; decimal is paced by the one-bit-per-cycle back-end converter.
// Reset (rst_n low, async): queue empty, converter idle, no output pending.
`default_nettype none

module integer_to_ascii_formatter_unit
    import ifa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ifa_req_if.sink    req,
    ifa_char_if.source chars
);

    localparam int CTL_W = $bits(ifa_ctl_t);
    localparam int Q_W   = CTL_W + VALUE_BITS;

    // front -> queue
    logic                  fq_valid;
    logic                  fq_ready;
    ifa_ctl_t              fq_ctl;
    logic [VALUE_BITS-1:0] fq_mag;

    // queue -> back
    logic                  qb_valid;
    logic                  qb_ready;
    logic [Q_W-1:0]        qb_data;
    ifa_ctl_t              qb_ctl;
    logic [VALUE_BITS-1:0] qb_mag;

    // Front: classify each request in the accept cycle, no state of its own.
    ifa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .req     (req),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_ctl   (fq_ctl),
        .q_mag   (fq_mag)
    );

    // Two-entry queue lets the next request be taken while the back end
    // is still converting or stalled on output.
    ifa_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_ctl, fq_mag}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    assign qb_ctl = qb_data[Q_W-1 -: CTL_W];
    assign qb_mag = qb_data[VALUE_BITS-1:0];

    // Back: digit conversion and character sequencing behind an output register.
    ifa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_ctl   (qb_ctl),
        .q_mag   (qb_mag),
        .chars   (chars)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench
    import ifa_pkg::*;
();

    // Generous cycle ceiling. The slowest legal run is about 460 requests of
    // eleven characters each, every character waiting out a slow receiver.
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_REQUESTS = 436;
    localparam int HOLD_AFTER      = 120;   // requests taken before the long sink stall
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_AT        = 200;   // random request index for the mid-run drain
    localparam int TAIL_CYCLES     = 60;
    localparam int DEC_SLOTS       = 10;    // decimal digits of a 32-bit magnitude

    // One character as seen on the output channel.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_result_t;

    // Directed row. An empty text means the predictor supplies the characters.
    typedef struct {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
        string              text;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ifa_req_if  req_ch ();
    ifa_char_if char_ch ();

    integer_to_ascii_formatter_unit #(
        .VALUE_BITS (VALUE_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .chars (char_ch)
    );

    always #2 clk = ~clk;

    // Characters still owed by the block, oldest first.
    char_result_t expected_chars [$];
    char_result_t want;

    // Predictor state: digits of the latest numeric request, LS digit first.
    logic [DIGIT_W-1:0] digit_slots [DEC_SLOTS];
    int                 digit_total;
    logic               minus_pending;

    int       failures          = 0;
    int       chars_checked     = 0;
    int       requests_accepted = 0;
    int       kind_count [4]    = '{0, 0, 0, 0};
    int       burst_left        = 0;
    int       cycle_count       = 0;
    logic     long_hold_done    = 1'b0;
    dir_row_t dir_rows [$];

    // Works out the characters one request produces.
    function automatic void format_request(input logic [1:0] kind,
                                           input logic [VALUE_W-1:0] val,
                                           output char_result_t run [$]);
        logic [CHAR_W-1:0]  code;
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] d;
        int                 radix;
        code = val[CHAR_W-1:0];
        run  = {};
        if (kind == KIND_TEXT || kind == KIND_RAW)
        begin
            // text mode expands a newline to CR LF; upper value bits are ignored
            if (kind == KIND_TEXT && code == CH_LF)
            begin
                run.push_back('{CH_CR, 1'b0});
            end
            run.push_back('{code, 1'b1});
            return;
        end
        if (kind == KIND_DEC)
        begin
            // most negative value wraps to itself: 2147483648 as unsigned
            minus_pending = val[VALUE_W-1];
            mag   = minus_pending ? (~val + 1'b1) : val;
            radix = 10;
        end
        else
        begin
            minus_pending = 1'b0;
            mag   = val;
            radix = 16;
        end
        digit_total = 0;
        do
        begin
            if (digit_total < DEC_SLOTS)
            begin
                digit_slots[digit_total] = DIGIT_W'(mag % radix);
                digit_total++;
            end
            mag = mag / radix;
        end
        while (mag != 0);
        if (minus_pending)
        begin
            run.push_back('{CH_MINUS, 1'b0});
        end
        for (int i = digit_total - 1; i >= 0; i--)
        begin
            d = digit_slots[i];
            run.push_back('{(d < 10) ? CH_ZERO + CHAR_W'(d) : CH_A + CHAR_W'(d) - 8'd10,
                            i == 0});
        end
    endfunction

    // Gap control: bursts of random length, random idle gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Offer one request and hold it until taken; the expectation is queued at
    // the accepting edge.
    task automatic send_request(input logic [1:0] kind, input logic [VALUE_W-1:0] val,
                                input string text);
        char_result_t run [$];
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= val;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        format_request(kind, val, run);
        if (text.len() != 0)
        begin
            // typed rows are checked against the literal text instead
            run = {};
            for (int i = 0; i < text.len(); i++)
            begin
                run.push_back('{text[i], i == text.len() - 1});
            end
        end
        foreach (run[i])
        begin
            expected_chars.push_back(run[i]);
        end
        requests_accepted++;
        kind_count[kind]++;
        pace_sender();
    endtask

    // Sender goes quiet until every owed character has come out.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Output sink: phases of steady, random, sparse and periodic ready, plus one long
    // stall once enough requests are in flight so the block backs up.
    initial
    begin : char_sink
        int phase;
        int span;
        int n;
        char_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && requests_accepted >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                char_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    @(posedge clk);
                end
            end
            phase = $urandom_range(0, 3);
            span  = $urandom_range(8, 60);
            for (n = 0; n < span; n++)
            begin
                case (phase)
                    0: char_ch.ready <= 1'b1;
                    1: char_ch.ready <= 1'($urandom_range(0, 1));
                    2: char_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: char_ch.ready <= ((n % 7) < 4);
                endcase
                @(posedge clk);
            end
        end
    end

    // Output check: every accepted character against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("out_char: expected none, got %02h (last_char %0b)",
                       char_ch.out_char, char_ch.last_char);
                failures++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_ch.out_char !== want.ch)
                begin
                    $error("out_char: expected %02h, got %02h", want.ch, char_ch.out_char);
                    failures++;
                end
                if (char_ch.last_char !== want.last)
                begin
                    $error("last_char: expected %0b, got %0b", want.last, char_ch.last_char);
                    failures++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d characters still owed",
                 cycle_count, expected_chars.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0]         kind;
        logic [VALUE_W-1:0] val;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= KIND_TEXT;
        req_ch.value    <= '0;
        rst_n = 1'b0;

        // Directed rows: numeric extremes, zero in both bases, sign handling,
        // newline expansion, raw vs text newline, character upper bits ignored.
        dir_rows = '{
            '{KIND_DEC,  32'h0000_0000, "0"},
            '{KIND_HEX,  32'h0000_0000, "0"},
            '{KIND_DEC,  32'h7FFF_FFFF, "2147483647"},
            '{KIND_DEC,  32'h8000_0000, "-2147483648"},
            '{KIND_DEC,  32'hFFFF_FFFF, "-1"},
            '{KIND_HEX,  32'hFFFF_FFFF, "ffffffff"},
            '{KIND_HEX,  32'h8000_0000, "80000000"},
            '{KIND_HEX,  32'hDEAD_BEEF, "deadbeef"},
            '{KIND_HEX,  32'h0000_000A, "a"},
            '{KIND_HEX,  32'h0000_0010, "10"},
            '{KIND_DEC,  32'd1,         "1"},
            '{KIND_DEC,  32'd1000000000, "1000000000"},
            '{KIND_DEC,  32'hFFFF_FFF6, "-10"},
            '{KIND_TEXT, 32'h0000_0041, "A"},
            '{KIND_TEXT, 32'hFFFF_FF41, "A"},
            '{KIND_RAW,  32'h0000_007A, "z"},
            '{KIND_TEXT, 32'h0000_000A, ""},
            '{KIND_TEXT, 32'hFFFF_FF0A, ""},
            '{KIND_RAW,  32'h0000_000A, ""},
            '{KIND_TEXT, 32'h0000_000D, ""},
            '{KIND_RAW,  32'h0000_0000, ""},
            '{KIND_RAW,  32'hFFFF_FFFF, ""},
            '{KIND_DEC,  32'h8000_0001, ""},
            '{KIND_HEX,  32'h0000_0000, "0"}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].text);
        end
        // sender pause: everything out before random traffic starts
        wait_for_drain();

        // Random part: full-range values mixed with small, negative,
        // power-of-two and newline-heavy values.
        for (int r = 0; r < RANDOM_REQUESTS; r++)
        begin
            kind = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: val = $urandom();
                1: val = VALUE_W'($urandom_range(0, 20));
                2: val = ~VALUE_W'($urandom_range(0, 20));
                3: val = (VALUE_W'(1) << $urandom_range(0, 31)) - VALUE_W'($urandom_range(0, 1));
                4: val = {24'($urandom() >> 8), CH_LF};
                default: val = VALUE_W'($urandom_range(0, 999999999));
            endcase
            send_request(kind, val, "");
            if (r == DRAIN_AT)
            begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        // a late extra character would still show within this window
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Requests: %0d text, %0d raw, %0d decimal, %0d hex; %0d characters checked",
                 kind_count[KIND_TEXT], kind_count[KIND_RAW], kind_count[KIND_DEC],
                 kind_count[KIND_HEX], chars_checked);
        $display("Sink stalled %0d cycles once with the sender still pushing; %0d cycles total",
                 HOLD_CYCLES, cycle_count);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
